// ===== src/rma_pkg.sv =====
`timescale 1ns / 1ps

package rma_pkg;

    localparam int N_ENTRIES = 9;
    localparam int CMD_W     = 2;
    localparam int ANGLE_W   = 16;
    localparam int S_TDATA_W = 24;
    localparam int STEP_W    = 5;
    localparam int ATAN_W    = 30;
    localparam int CORDIC_W  = 33;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [1:0] LAST_ROW = 2'd2;

    typedef enum logic [1:0] {
        CMD_IDENTITY = 2'd0,
        CMD_ROT_X    = 2'd1,
        CMD_ROT_Y    = 2'd2,
        CMD_ROT_Z    = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        MUL_AC,
        MUL_BS,
        MUL_BC,
        MUL_AS
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_CONV,
        ST_RD_A,
        ST_RD_B,
        ST_MUL_BS,
        ST_MUL_BC,
        ST_MUL_AS,
        ST_ACC_Q,
        ST_WR_Q,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              accept;
        logic              cordic_step;
        logic [STEP_W-1:0] step_idx;
        logic              conv;
        logic [1:0]        row;
        logic              rd_a;
        logic              rd_b;
        logic              mul_en;
        mul_sel_t          mul_sel;
        acc_op_t           acc_op;
        logic              wr_p;
        logic              wr_q;
        logic              out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic in_identity;
        logic out_free;
    } dp_status_t;

    // atan(2^-i) as a fraction of a half turn, 2^31 = pi
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            5'd24:   v = 30'd41;
            5'd25:   v = 30'd20;
            5'd26:   v = 30'd10;
            5'd27:   v = 30'd5;
            5'd28:   v = 30'd3;
            5'd29:   v = 30'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/rma_ctrl.sv =====
`timescale 1ns / 1ps

module rma_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  rma_pkg::dp_status_t status,
    output rma_pkg::dp_cmd_t    cmd
);

    localparam logic [rma_pkg::STEP_W-1:0] LAST_STEP = rma_pkg::STEP_W'(CORDIC_STEPS - 1);

    rma_pkg::state_t              state_reg, state_next;
    logic [rma_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [1:0]                   row_reg, row_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rma_pkg::ST_IDLE;
            step_reg  <= '0;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            row_reg   <= row_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        row_next   = row_reg;
        case (state_reg)
            rma_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    step_next  = '0;
                    row_next   = '0;
                    state_next = status.in_identity ? rma_pkg::ST_DONE : rma_pkg::ST_CORDIC;
                end
            end
            rma_pkg::ST_CORDIC: begin
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = rma_pkg::ST_CONV;
                end
            end
            rma_pkg::ST_CONV:   state_next = rma_pkg::ST_RD_A;
            rma_pkg::ST_RD_A:   state_next = rma_pkg::ST_RD_B;
            rma_pkg::ST_RD_B:   state_next = rma_pkg::ST_MUL_BS;
            rma_pkg::ST_MUL_BS: state_next = rma_pkg::ST_MUL_BC;
            rma_pkg::ST_MUL_BC: state_next = rma_pkg::ST_MUL_AS;
            rma_pkg::ST_MUL_AS: state_next = rma_pkg::ST_ACC_Q;
            rma_pkg::ST_ACC_Q:  state_next = rma_pkg::ST_WR_Q;
            rma_pkg::ST_WR_Q: begin
                if (row_reg == rma_pkg::LAST_ROW) begin
                    state_next = rma_pkg::ST_DONE;
                end else begin
                    row_next   = row_reg + 1'b1;
                    state_next = rma_pkg::ST_RD_A;
                end
            end
            rma_pkg::ST_DONE: begin
                if (status.out_free) begin
                    state_next = rma_pkg::ST_IDLE;
                end
            end
            default: state_next = rma_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.mul_sel  = rma_pkg::MUL_AC;
        cmd.acc_op   = rma_pkg::ACC_HOLD;
        cmd.step_idx = step_reg;
        cmd.row      = row_reg;
        s_tready     = 1'b0;
        case (state_reg)
            rma_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            rma_pkg::ST_CORDIC: cmd.cordic_step = 1'b1;
            rma_pkg::ST_CONV:   cmd.conv = 1'b1;
            rma_pkg::ST_RD_A:   cmd.rd_a = 1'b1;
            rma_pkg::ST_RD_B: begin
                cmd.rd_b    = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rma_pkg::MUL_AC;
            end
            rma_pkg::ST_MUL_BS: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rma_pkg::MUL_BS;
                cmd.acc_op  = rma_pkg::ACC_LOAD;
            end
            rma_pkg::ST_MUL_BC: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rma_pkg::MUL_BC;
                cmd.acc_op  = rma_pkg::ACC_ADD;
            end
            rma_pkg::ST_MUL_AS: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rma_pkg::MUL_AS;
                cmd.acc_op  = rma_pkg::ACC_LOAD;
                cmd.wr_p    = 1'b1;
            end
            rma_pkg::ST_ACC_Q:  cmd.acc_op = rma_pkg::ACC_SUB;
            rma_pkg::ST_WR_Q:   cmd.wr_q = 1'b1;
            rma_pkg::ST_DONE:   cmd.out_load = status.out_free;
            default: ;
        endcase
    end

endmodule

// ===== src/rma_datapath.sv =====
`timescale 1ns / 1ps

module rma_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rma_pkg::dp_cmd_t                    cmd,
    output rma_pkg::dp_status_t                 status,
    input  logic [rma_pkg::CMD_W-1:0]           in_command,
    input  logic signed [rma_pkg::ANGLE_W-1:0]  in_angle,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [FRAC_BITS+1:0]         out_entry [rma_pkg::N_ENTRIES]
);

    localparam int W      = FRAC_BITS + 2;
    localparam int PROD_W = 2 * W;
    localparam int CW     = rma_pkg::CORDIC_W;
    localparam int SH     = 30 - FRAC_BITS;

    localparam logic signed [W-1:0]      ONE_W  = W'(2 ** FRAC_BITS);
    localparam logic signed [CW-1:0]     ONE_CW = CW'(2 ** FRAC_BITS);
    localparam logic signed [PROD_W-1:0] ONE_P  = PROD_W'(2 ** FRAC_BITS);
    localparam logic signed [CW-1:0]     HALF_Q = CW'((2 ** SH) / 2);
    localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(2 ** (FRAC_BITS - 1));

    function automatic logic [3:0] entry_idx(input logic [1:0] row, input logic [1:0] col);
        return 4'(row) * 4'd3 + 4'(col);
    endfunction

    function automatic logic signed [W-1:0] sat_cw(input logic signed [CW-1:0] v);
        logic signed [W-1:0] r;
        if (v > ONE_CW) begin
            r = ONE_W;
        end else if (v < -ONE_CW) begin
            r = -ONE_W;
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] sat_p(input logic signed [PROD_W-1:0] v);
        logic signed [W-1:0] r;
        if (v > ONE_P) begin
            r = ONE_W;
        end else if (v < -ONE_P) begin
            r = -ONE_W;
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    rma_pkg::cmd_code_t        op_reg;
    logic                      flip_reg;
    logic signed [CW-1:0]      x_reg, y_reg, z_reg;
    logic signed [W-1:0]       c_reg, s_reg, a_reg, b_reg;
    logic signed [PROD_W-1:0]  prod_reg, acc_reg;
    logic signed [W-1:0]       mat_reg [rma_pkg::N_ENTRIES];
    logic signed [W-1:0]       out_reg [rma_pkg::N_ENTRIES];
    logic                      out_valid_reg;

    logic [31:0]               phase;
    logic                      flip_in;
    logic signed [CW-1:0]      z_init;
    logic signed [CW-1:0]      dx, dy, at_val;
    logic signed [CW-1:0]      xf, yf, xr, yr;
    logic [1:0]                col_p, col_q;
    logic [3:0]                rd_idx, wr_idx;
    logic signed [W-1:0]       rd_val;
    logic signed [W-1:0]       mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_full;
    logic signed [PROD_W-1:0]  acc_shift;
    logic signed [W-1:0]       wr_val;
    logic                      load_identity;

    // quadrants 1 and 2 are folded by a half turn, results negated at the end
    assign phase   = {in_angle, 16'b0};
    assign flip_in = phase[31] ^ phase[30];
    assign z_init  = CW'(signed'({phase[31] ^ flip_in, phase[30:0]}));

    assign dx     = y_reg >>> cmd.step_idx;
    assign dy     = x_reg >>> cmd.step_idx;
    assign at_val = CW'(rma_pkg::atan_lut(cmd.step_idx));

    assign xf = flip_reg ? -x_reg : x_reg;
    assign yf = flip_reg ? -y_reg : y_reg;
    assign xr = (xf + HALF_Q) >>> SH;
    assign yr = (yf + HALF_Q) >>> SH;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= rma_pkg::cmd_code_t'(in_command);
            flip_reg <= flip_in;
            x_reg    <= rma_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= z_init;
        end else if (cmd.cordic_step) begin
            if (!z_reg[CW-1]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at_val;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at_val;
            end
        end
        if (cmd.conv) begin
            c_reg <= sat_cw(xr);
            s_reg <= sat_cw(yr);
        end
    end

    always_comb begin
        case (op_reg)
            rma_pkg::CMD_ROT_X: begin
                col_p = 2'd1;
                col_q = 2'd2;
            end
            rma_pkg::CMD_ROT_Y: begin
                col_p = 2'd2;
                col_q = 2'd0;
            end
            rma_pkg::CMD_ROT_Z: begin
                col_p = 2'd0;
                col_q = 2'd1;
            end
            default: begin
                col_p = 2'd0;
                col_q = 2'd1;
            end
        endcase
    end

    assign rd_idx = entry_idx(cmd.row, cmd.rd_a ? col_p : col_q);
    assign wr_idx = entry_idx(cmd.row, cmd.wr_p ? col_p : col_q);
    assign rd_val = mat_reg[rd_idx];

    always_ff @(posedge aclk) begin
        if (cmd.rd_a) begin
            a_reg <= rd_val;
        end
        if (cmd.rd_b) begin
            b_reg <= rd_val;
        end
    end

    always_comb begin
        case (cmd.mul_sel)
            rma_pkg::MUL_AC: begin
                mul_a = a_reg;
                mul_b = c_reg;
            end
            rma_pkg::MUL_BS: begin
                mul_a = b_reg;
                mul_b = s_reg;
            end
            rma_pkg::MUL_BC: begin
                mul_a = b_reg;
                mul_b = c_reg;
            end
            rma_pkg::MUL_AS: begin
                mul_a = a_reg;
                mul_b = s_reg;
            end
            default: begin
                mul_a = a_reg;
                mul_b = c_reg;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mul_full;
        end
        case (cmd.acc_op)
            rma_pkg::ACC_LOAD: acc_reg <= prod_reg + HALF_P;
            rma_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_reg;
            rma_pkg::ACC_SUB:  acc_reg <= acc_reg - prod_reg;
            default:           acc_reg <= acc_reg;
        endcase
    end

    assign acc_shift     = acc_reg >>> FRAC_BITS;
    assign wr_val        = sat_p(acc_shift);
    assign load_identity = cmd.accept &&
                           (rma_pkg::cmd_code_t'(in_command) == rma_pkg::CMD_IDENTITY);

    always_ff @(posedge aclk) begin
        if (!aresetn || load_identity) begin
            for (int k = 0; k < rma_pkg::N_ENTRIES; k++) begin
                mat_reg[k] <= (k % 4 == 0) ? ONE_W : '0;
            end
        end else if (cmd.wr_p || cmd.wr_q) begin
            mat_reg[wr_idx] <= wr_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= mat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_entry          = out_reg;
    assign status.in_identity = (rma_pkg::cmd_code_t'(in_command) == rma_pkg::CMD_IDENTITY);
    assign status.out_free    = !out_valid_reg || out_ready;

endmodule

// ===== src/rotation_matrix_accumulator_unit.sv =====
`timescale 1ns / 1ps

// Keeps a 3x3 rotation matrix (FRAC_BITS fraction bits, entries saturated to
// +-1.0) and, for each input transaction, either loads the identity or
// post-multiplies it by a rotation about X, Y or Z; all nine entries are then
// sent as one output transaction. A rotation runs through the accept, one
// CORDIC step per cycle for sine and cosine, a conversion, then for each
// matrix row a pass through a single shared multiplier and accumulator, and
// finally the load of the output register, which waits until that register is
// free; m_tvalid is registered from that load. An identity load goes from the
// accept straight to the output load. The next transaction is accepted the
// cycle after the result is loaded, even while that result waits on m_tready.
// After reset the matrix is the identity.
module rotation_matrix_accumulator_unit #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // [1:0] command, [17:2] angle, [23:18] zero
    input  logic [rma_pkg::S_TDATA_W-1:0]               s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // FRAC_BITS+2 bits each from bit 0: m00 m01 m02 m10 m11 m12 m20 m21 m22, zero pad
    output logic [((9 * (FRAC_BITS + 2) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int W      = FRAC_BITS + 2;
    localparam int DATA_W = rma_pkg::N_ENTRIES * W;
    localparam int M_W    = ((DATA_W + 7) / 8) * 8;

    rma_pkg::dp_cmd_t    dp_cmd;
    rma_pkg::dp_status_t dp_status;
    logic signed [W-1:0] out_entry [rma_pkg::N_ENTRIES];

    rma_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    rma_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (dp_cmd),
        .status     (dp_status),
        .in_command (s_tdata[rma_pkg::CMD_W-1:0]),
        .in_angle   (signed'(s_tdata[rma_pkg::CMD_W +: rma_pkg::ANGLE_W])),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_entry  (out_entry)
    );

    for (genvar k = 0; k < rma_pkg::N_ENTRIES; k++) begin : g_pack
        assign m_tdata[k*W +: W] = out_entry[k];
    end

    if (M_W > DATA_W) begin : g_pad
        assign m_tdata[M_W-1:DATA_W] = '0;
    end

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a transaction is in progress");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.out_load |-> dp_status.out_free)
        else $error("output register overwritten before it was taken");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.out_load |=> m_tvalid)
        else $error("result loaded but not presented");

    a_one_matrix_access: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({dp_cmd.rd_a, dp_cmd.rd_b, dp_cmd.wr_p, dp_cmd.wr_q,
                  dp_cmd.cordic_step, dp_cmd.conv}))
        else $error("conflicting datapath operations in one cycle");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int FRAC       = 16;
    localparam int STEPS      = 16;
    localparam int ENTRY_W    = FRAC + 2;
    localparam int M_TDATA_W  = ((9 * ENTRY_W + 7) / 8) * 8;
    localparam longint UNIT   = longint'(1) << FRAC;
    localparam longint GAIN   = 64'sd652032874;
    localparam int CYCLE_LIMIT = 500000;

    localparam longint ATAN_HALF_TURN [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    typedef logic [8:0][ENTRY_W-1:0] matrix_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    // [1:0] command, [17:2] angle, [23:18] zero
    logic [rma_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    // ENTRY_W bits each from bit 0: m00 m01 m02 m10 m11 m12 m20 m21 m22, zero pad
    logic [M_TDATA_W-1:0]          m_tdata;

    longint  rot_mat [9];
    matrix_t matrix_expect_q [$];
    string   entry_name [9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                                "m20", "m21", "m22"};

    int src_idle_pct;
    int sink_stall_pct;
    int n_sent;
    int n_rot;
    int n_checked;
    int n_err;
    int cycle_cnt;

    rotation_matrix_accumulator_unit #(
        .FRAC_BITS    (FRAC),
        .CORDIC_STEPS (STEPS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint clamp_unit(input longint v);
        if (v > UNIT) return UNIT;
        if (v < -UNIT) return -UNIT;
        return v;
    endfunction

    // rotation-mode CORDIC, Q2.30 internally, result in FRAC fraction bits
    function automatic void cordic_cos_sin(input logic [15:0] ang,
                                           output longint cs, output longint sn);
        logic [31:0] phase;
        logic        flip;
        longint      x, y, z, dx, dy;
        int          i;
        phase = {ang, 16'h0};
        flip  = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
        if (flip) phase = phase + 32'h8000_0000;
        z = longint'($signed(phase));
        x = GAIN;
        y = 0;
        for (i = 0; i < STEPS && i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_HALF_TURN[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_HALF_TURN[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = clamp_unit((x + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC));
        sn = clamp_unit((y + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC));
    endfunction

    function automatic longint mac_round(input longint prod_sum);
        return clamp_unit((prod_sum + (longint'(1) << (FRAC - 1))) >>> FRAC);
    endfunction

    function automatic matrix_t apply_command(input rma_pkg::cmd_code_t cmd,
                                              input logic [15:0] ang);
        matrix_t res;
        longint  c, s, a, b;
        int      p, q, r;
        if (cmd == rma_pkg::CMD_IDENTITY) begin
            for (r = 0; r < 9; r++) rot_mat[r] = (r % 4 == 0) ? UNIT : 0;
        end else begin
            cordic_cos_sin(ang, c, s);
            case (cmd)
                rma_pkg::CMD_ROT_X: begin p = 1; q = 2; end
                rma_pkg::CMD_ROT_Y: begin p = 2; q = 0; end
                default:            begin p = 0; q = 1; end
            endcase
            for (r = 0; r < 3; r++) begin
                a = rot_mat[r * 3 + p];
                b = rot_mat[r * 3 + q];
                rot_mat[r * 3 + p] = mac_round(a * c + b * s);
                rot_mat[r * 3 + q] = mac_round(b * c - a * s);
            end
        end
        for (r = 0; r < 9; r++) res[r] = rot_mat[r][ENTRY_W-1:0];
        return res;
    endfunction

    task automatic send_command(input rma_pkg::cmd_code_t cmd, input logic [15:0] ang);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(rma_pkg::S_TDATA_W - rma_pkg::CMD_W - rma_pkg::ANGLE_W){1'b0}},
                     ang, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        matrix_expect_q.push_back(apply_command(cmd, ang));
        n_sent++;
        if (cmd != rma_pkg::CMD_IDENTITY) n_rot++;
    endtask

    task automatic check_matrix(input matrix_t got);
        matrix_t want;
        int      k;
        if (matrix_expect_q.size() == 0) begin
            $display("%0t: unexpected result transaction, got %h", $time, got);
            n_err++;
        end else begin
            want = matrix_expect_q.pop_front();
            for (k = 0; k < 9; k++) begin
                if (got[k] !== want[k]) begin
                    $display("%0t: %s expected %0d got %0d", $time, entry_name[k],
                             $signed(want[k]), $signed(got[k]));
                    n_err++;
                end
            end
            n_checked++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_matrix(m_tdata[9*ENTRY_W-1:0]);
        m_tready <= aresetn && ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
                     matrix_expect_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_identity_load;
        send_command(rma_pkg::CMD_IDENTITY, 16'h0000);
        send_command(rma_pkg::CMD_ROT_Z, 16'd5000);
        send_command(rma_pkg::CMD_IDENTITY, 16'h8000);
        send_command(rma_pkg::CMD_ROT_X, 16'd12345);
        send_command(rma_pkg::CMD_IDENTITY, 16'h7FFF);
    endtask

    // quadrant edges exercise the pi flip of the CORDIC input
    task automatic test_axis_quadrants;
        send_command(rma_pkg::CMD_ROT_X, 16'd0);
        send_command(rma_pkg::CMD_ROT_X, 16'd16384);
        send_command(rma_pkg::CMD_ROT_X, 16'hC000);
        send_command(rma_pkg::CMD_ROT_X, 16'd16383);
        send_command(rma_pkg::CMD_ROT_Y, 16'h7FFF);
        send_command(rma_pkg::CMD_ROT_Y, 16'h8000);
        send_command(rma_pkg::CMD_ROT_Y, 16'hBFFF);
        send_command(rma_pkg::CMD_ROT_Y, 16'd8192);
        send_command(rma_pkg::CMD_ROT_Z, 16'd1);
        send_command(rma_pkg::CMD_ROT_Z, 16'hFFFF);
        send_command(rma_pkg::CMD_ROT_Z, 16'd24576);
        send_command(rma_pkg::CMD_ROT_Z, 16'hA000);
        send_command(rma_pkg::CMD_IDENTITY, 16'h5555);
    endtask

    // zero angle from identity drives entries onto the +-1.0 clamp
    task automatic test_unit_saturation;
        send_command(rma_pkg::CMD_ROT_Z, 16'd0);
        send_command(rma_pkg::CMD_ROT_X, 16'd0);
        send_command(rma_pkg::CMD_ROT_Y, 16'd0);
        send_command(rma_pkg::CMD_ROT_Y, 16'h8000);
        send_command(rma_pkg::CMD_ROT_Z, 16'h8000);
    endtask

    task automatic test_random_stream(input int n_items, input int idle_pct,
                                      input int stall_pct);
        rma_pkg::cmd_code_t cmd;
        logic [15:0]        ang;
        int                 i;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 10) cmd = rma_pkg::CMD_IDENTITY;
            else cmd = rma_pkg::cmd_code_t'($urandom_range(3, 1));
            if ($urandom_range(99) < 25) ang = 16'($urandom_range(1023) - 512);
            else ang = 16'($urandom);
            send_command(cmd, ang);
        end
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        n_sent         = 0;
        n_rot          = 0;
        for (int r = 0; r < 9; r++) rot_mat[r] = (r % 4 == 0) ? UNIT : 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_identity_load();
        test_axis_quadrants();
        test_unit_saturation();
        test_random_stream(150, 0, 0);
        test_random_stream(150, 51, 0);
        test_random_stream(150, 0, 51);
        test_random_stream(150, 21, 21);

        s_tvalid <= 1'b0;
        while (matrix_expect_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("sent %0d commands (%0d rotations), checked %0d matrices", n_sent, n_rot,
                 n_checked);
        $display("covered identity loads, all axes, quadrant edges and handshake stalls");
        if (n_err == 0 && matrix_expect_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/rma_pkg.sv
src/rma_ctrl.sv
src/rma_datapath.sv
src/rotation_matrix_accumulator_unit.sv
tb/sv/tb.sv
